// ===== rtl/npg_pkg.sv =====
// ----------------------------------------------------------------------------
// npg_pkg
// Types and state codes shared by the next permutation generator modules.
// ----------------------------------------------------------------------------
package npg_pkg;

    // element values and positions, wide enough for counts up to 15
    typedef logic [3:0] t_val;
    typedef logic [3:0] t_pos;

    // write port of the permutation store
    typedef struct packed {
        logic en;
        t_pos addr;
        t_val data;
    } t_ram_wr;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_ASC_RD,
        S_ASC_CHK,
        S_SUC_RD,
        S_SUC_CHK,
        S_SWP1,
        S_SWP2,
        S_REV_RD,
        S_REV_W1,
        S_REV_W2,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EXH
    } t_state;

endpackage

// ===== rtl/next_permutation_generator.sv =====
// ----------------------------------------------------------------------------
// next_permutation_generator
// Lexicographic next permutation of 1..n, streamed one element per word.
// ----------------------------------------------------------------------------
// Each input word asks for the next permutation (or the identity on restart,
// on the first request, and after element_count is written) and is answered
// by n output words, one element each, tlast on the final one; when no
// permutation follows, a single word with tuser set and zero data is sent.
// The permutation lives in a small memory with one write port, and one
// comparator is shared by a small sequencer, so a request steps through:
// the identity is written element by element; a next permutation scans for
// the rightmost ascent, scans for the successor, swaps the two, reverses the
// suffix pair by pair, then emits each element, and output stalls hold the
// emit steps; an exhausted answer sends its single word. A new request is taken
// only in idle, while the last result word may still wait at the output.
// ----------------------------------------------------------------------------
module next_permutation_generator #(
    parameter int MAX_ELEMENTS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,     // element_count
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [0] restart, [7:1] zero
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [3:0] element_value, [6:4] position, [7] zero
    output logic       m_axis_tlast,    // last_of_run
    output logic       m_axis_tuser     // exhausted
);
    import npg_pkg::*;

    localparam logic [4:0] MaxN = 5'(MAX_ELEMENTS);

    t_state     r_state, n_state;
    logic [3:0] r_count;
    logic       r_started, n_started;
    t_pos       r_idx, n_idx;
    t_pos       r_hi, n_hi;
    t_pos       r_piv, n_piv;
    t_pos       r_best, n_best;
    t_val       r_pivval, n_pivval;
    t_val       r_bestval, n_bestval;

    logic       r_out_valid, n_out_valid;
    t_val       r_out_val, n_out_val;
    logic [2:0] r_out_pos, n_out_pos;
    logic       r_out_last, n_out_last;
    logic       r_out_exh, n_out_exh;

    logic [4:0] w_n;
    t_pos       w_last;
    logic       w_accept;
    logic       w_restart;
    logic       w_out_free;
    t_val       w_cmp_a, w_cmp_b;
    logic       w_cmp_lt;

    t_ram_wr    w_wr;
    logic       w_rd_en;
    t_pos       w_rd_a_addr, w_rd_b_addr;
    t_val       w_rd_a, w_rd_b;

    npg_perm_ram #(
        .DEPTH(MAX_ELEMENTS)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr        (w_wr),
        .i_rd_en     (w_rd_en),
        .i_rd_a_addr (w_rd_a_addr),
        .i_rd_b_addr (w_rd_b_addr),
        .o_rd_a_data (w_rd_a),
        .o_rd_b_data (w_rd_b)
    );

    // effective count, clamped to 1..MAX_ELEMENTS
    always_comb begin
        if (r_count == 4'd0) begin
            w_n = 5'd1;
        end else if ({1'b0, r_count} > MaxN) begin
            w_n = MaxN;
        end else begin
            w_n = {1'b0, r_count};
        end
    end
    assign w_last = 4'(w_n - 5'd1);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_restart     = s_axis_tdata[0];
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // shared comparator
    always_comb begin
        if (r_state == S_SUC_CHK) begin
            w_cmp_a = r_pivval;
            w_cmp_b = w_rd_a;
        end else begin
            w_cmp_a = w_rd_a;
            w_cmp_b = w_rd_b;
        end
    end
    assign w_cmp_lt = (w_cmp_a < w_cmp_b);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_restart || !r_started) begin
                        n_state = S_INIT;
                    end else if (w_last == 4'd0) begin
                        n_state = S_EXH;
                    end else begin
                        n_state = S_ASC_RD;
                    end
                end
            end
            S_INIT: begin
                if (r_idx == w_last) begin
                    n_state = S_EMIT_RD;
                end
            end
            S_ASC_RD:  n_state = S_ASC_CHK;
            S_ASC_CHK: begin
                if (w_cmp_lt) begin
                    n_state = S_SUC_RD;
                end else if (r_idx == 4'd1) begin
                    n_state = S_EXH;
                end else begin
                    n_state = S_ASC_RD;
                end
            end
            S_SUC_RD:  n_state = S_SUC_CHK;
            S_SUC_CHK: begin
                if (w_cmp_lt) begin
                    n_state = S_SWP1;
                end else begin
                    n_state = S_SUC_RD;
                end
            end
            S_SWP1:    n_state = S_SWP2;
            S_SWP2: begin
                if ((r_piv + 4'd1) < w_last) begin
                    n_state = S_REV_RD;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            S_REV_RD:  n_state = S_REV_W1;
            S_REV_W1:  n_state = S_REV_W2;
            S_REV_W2: begin
                if ((r_idx + 4'd1) < (r_hi - 4'd1)) begin
                    n_state = S_REV_RD;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: n_state = S_EMIT_LD;
            S_EMIT_LD: begin
                if (w_out_free) begin
                    if (r_idx == w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_EXH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_started   = r_started;
        n_idx       = r_idx;
        n_hi        = r_hi;
        n_piv       = r_piv;
        n_best      = r_best;
        n_pivval    = r_pivval;
        n_bestval   = r_bestval;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_val   = r_out_val;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;
        n_out_exh   = r_out_exh;
        w_wr        = '0;
        w_rd_en     = 1'b0;
        w_rd_a_addr = r_idx;
        w_rd_b_addr = r_hi;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_restart || !r_started) begin
                        n_idx = 4'd0;
                    end else begin
                        n_idx = w_last;
                    end
                end
            end
            S_INIT: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_idx;
                w_wr.data = r_idx + 4'd1;
                if (r_idx == w_last) begin
                    n_started = 1'b1;
                    n_idx     = 4'd0;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            S_ASC_RD: begin
                w_rd_en     = 1'b1;
                w_rd_a_addr = r_idx - 4'd1;
                w_rd_b_addr = r_idx;
            end
            S_ASC_CHK: begin
                if (w_cmp_lt) begin
                    n_piv    = r_idx - 4'd1;
                    n_pivval = w_rd_a;
                    n_idx    = w_last;
                end else begin
                    n_idx = r_idx - 4'd1;
                end
            end
            S_SUC_RD: begin
                w_rd_en     = 1'b1;
                w_rd_a_addr = r_idx;
            end
            S_SUC_CHK: begin
                // suffix is descending: first larger value from the right is the successor
                if (w_cmp_lt) begin
                    n_best    = r_idx;
                    n_bestval = w_rd_a;
                end else begin
                    n_idx = r_idx - 4'd1;
                end
            end
            S_SWP1: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_piv;
                w_wr.data = r_bestval;
            end
            S_SWP2: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_best;
                w_wr.data = r_pivval;
                if ((r_piv + 4'd1) < w_last) begin
                    n_idx = r_piv + 4'd1;
                    n_hi  = w_last;
                end else begin
                    n_idx = 4'd0;
                end
            end
            S_REV_RD: begin
                // suffix stays descending after the swap, so sorting is a reversal
                w_rd_en     = 1'b1;
                w_rd_a_addr = r_idx;
                w_rd_b_addr = r_hi;
            end
            S_REV_W1: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_idx;
                w_wr.data = w_rd_b;
            end
            S_REV_W2: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_hi;
                w_wr.data = w_rd_a;
                if ((r_idx + 4'd1) < (r_hi - 4'd1)) begin
                    n_idx = r_idx + 4'd1;
                    n_hi  = r_hi - 4'd1;
                end else begin
                    n_idx = 4'd0;
                end
            end
            S_EMIT_RD: begin
                w_rd_en     = 1'b1;
                w_rd_a_addr = r_idx;
            end
            S_EMIT_LD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_val   = w_rd_a;
                    n_out_pos   = r_idx[2:0];
                    n_out_last  = (r_idx == w_last);
                    n_out_exh   = 1'b0;
                    if (r_idx != w_last) begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            S_EXH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_val   = '0;
                    n_out_pos   = '0;
                    n_out_last  = 1'b1;
                    n_out_exh   = 1'b1;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
        // a count write restarts from the identity
        if (i_cfg_we) begin
            n_started = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= 4'd4;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_hi       <= n_hi;
        r_piv      <= n_piv;
        r_best     <= n_best;
        r_pivval   <= n_pivval;
        r_bestval  <= n_bestval;
        r_out_val  <= n_out_val;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
        r_out_exh  <= n_out_exh;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_pos, r_out_val};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_exh;

    // exhausted word is a lone zero word closing its run
    a_exh_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
        else $error("exhausted word malformed");

    // an accepted request makes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready right after accept");

    // the chosen successor is larger than the pivot value
    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWP1) |-> (r_pivval < r_bestval))
        else $error("successor not larger than pivot");

    // result loads only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
        else $error("stalled output word changed");

endmodule

// ===== rtl/npg_perm_ram.sv =====
// ----------------------------------------------------------------------------
// npg_perm_ram
// Permutation store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module npg_perm_ram #(
    parameter int DEPTH = 8
) (
    input  logic           i_clk,
    input  npg_pkg::t_ram_wr i_wr,
    input  logic           i_rd_en,
    input  npg_pkg::t_pos  i_rd_a_addr,
    input  npg_pkg::t_pos  i_rd_b_addr,
    output npg_pkg::t_val  o_rd_a_data,
    output npg_pkg::t_val  o_rd_b_data
);
    import npg_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_val r_mem [DEPTH];
    t_val r_rd_a;
    t_val r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[IW-1:0]] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_a_addr[IW-1:0]];
            r_rd_b <= r_mem[i_rd_b_addr[IW-1:0]];
        end
    end

    assign o_rd_a_data = r_rd_a;
    assign o_rd_b_data = r_rd_b;

endmodule

// ===== tb/sv/next_permutation_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_permutation_generator_tb
// Self-checking stream testbench for the next permutation generator.
// ----------------------------------------------------------------------------
// Requests go in on the slave stream. A behavioral copy of the permutation
// state predicts the words each accepted request must produce: the identity
// after reset, restart or a count write, the lexicographic successor
// otherwise, or a single exhausted word. Every output word is compared with
// the oldest prediction. Directed runs cover the count extremes and a full
// walk to exhaustion, then random runs mix sizes, restarts, drains and
// random stalls on both sides.
// ----------------------------------------------------------------------------
module next_permutation_generator_tb;

    import npg_pkg::*;

    localparam int MAX_ELEMENTS   = 8;
    localparam int RANDOM_ITEMS   = 245;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [3:0] value;
        logic [2:0] pos;
        logic       last;
        logic       exhausted;
    } t_perm_word;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic [3:0] i_cfg_wdata   = 4'd0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'd0;   // [0] restart, [7:1] zero
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [3:0] element_value, [6:4] position, [7] zero
    logic       m_axis_tlast;           // last_of_run
    logic       m_axis_tuser;           // exhausted

    // predictor state
    t_val       perm_values [MAX_ELEMENTS];
    logic [3:0] count_reg     = 4'd4;
    bit         perm_started  = 1'b0;
    t_perm_word expected_words [$];

    int errors      = 0;
    int idle_cycles = 0;
    bit steady      = 1'b0;

    next_permutation_generator #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int active_count();
        if (count_reg == 4'd0) begin
            return 1;
        end
        if (count_reg > MAX_ELEMENTS) begin
            return MAX_ELEMENTS;
        end
        return int'(count_reg);
    endfunction

    function automatic void queue_permutation(input int n);
        t_perm_word w;
        for (int k = 0; k < n; k++) begin
            w.value     = perm_values[k];
            w.pos       = k[2:0];
            w.last      = (k == n - 1);
            w.exhausted = 1'b0;
            expected_words.insert(expected_words.size(), w);
        end
    endfunction

    function automatic void advance_permutation(input logic restart);
        int   n;
        int   pivot;
        int   succ;
        int   lo;
        int   hi;
        bit   found;
        t_val tmp;
        t_perm_word w;
        n = active_count();
        if (restart || !perm_started) begin
            for (int k = 0; k < n; k++) begin
                perm_values[k] = t_val'(k + 1);
            end
            perm_started = 1'b1;
            queue_permutation(n);
            return;
        end
        found = 1'b0;
        pivot = 0;
        for (int k = n - 1; k > 0 && !found; k--) begin
            if (perm_values[k - 1] < perm_values[k]) begin
                pivot = k - 1;
                found = 1'b1;
            end
        end
        if (!found) begin
            w = '{value: 4'd0, pos: 3'd0, last: 1'b1, exhausted: 1'b1};
            expected_words.insert(expected_words.size(), w);
            return;
        end
        succ = pivot + 1;
        for (int k = pivot + 1; k < n; k++) begin
            if (perm_values[k] > perm_values[pivot] && perm_values[k] < perm_values[succ]) begin
                succ = k;
            end
        end
        tmp                = perm_values[pivot];
        perm_values[pivot] = perm_values[succ];
        perm_values[succ]  = tmp;
        // suffix is descending after the swap, so reversing sorts it
        lo = pivot + 1;
        hi = n - 1;
        while (lo < hi) begin
            tmp             = perm_values[lo];
            perm_values[lo] = perm_values[hi];
            perm_values[hi] = tmp;
            lo++;
            hi--;
        end
        queue_permutation(n);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_request(input logic restart);
        while (!steady && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_permutation(restart);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    task automatic write_element_count(input logic [3:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        count_reg    = count;
        perm_started = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_count();
        // reset size 4: identity, two successors, restart, successor
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain_results();
    endtask

    task automatic test_single_element();
        write_element_count(4'd1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        drain_results();
        // zero count behaves as one element
        write_element_count(4'd0);
        send_request(1'b0);
        send_request(1'b0);
        drain_results();
    endtask

    task automatic test_full_walk();
        write_element_count(4'd3);
        // six permutations, then exhausted twice
        for (int k = 0; k < 8; k++) begin
            send_request(1'b0);
        end
        drain_results();
    endtask

    task automatic test_wide_count();
        // count above the maximum is clamped
        write_element_count(4'd15);
        send_request(1'b0);
        send_request(1'b0);
        drain_results();
        write_element_count(4'd8);
        send_request(1'b0);
        send_request(1'b1);
        drain_results();
    endtask

    task automatic test_random_runs();
        int         sent;
        int         run;
        int         n;
        int         len;
        int         pick;
        logic [3:0] count;
        sent = 0;
        run  = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                count = 4'($urandom_range(1, 2));
            end else if (pick < 35) begin
                count = 4'd3;
            end else if (pick < 60) begin
                count = 4'd4;
            end else if (pick < 68) begin
                count = 4'd0;
            end else if (pick < 80) begin
                count = 4'($urandom_range(5, 7));
            end else if (pick < 90) begin
                count = 4'd8;
            end else begin
                count = 4'($urandom_range(9, 15));
            end
            drain_results();
            steady = (run == 2);
            write_element_count(count);
            n = active_count();
            // small sizes run past exhaustion, large ones stay short
            if (n <= 4) begin
                len = ((n == 4) ? 24 : (n == 3) ? 6 : n) + $urandom_range(1, 3);
            end else begin
                len = $urandom_range(8, 30);
            end
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < 8) begin
                    drain_results();
                end
                send_request($urandom_range(0, 99) < 4);
                sent++;
            end
            run++;
        end
        drain_results();
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge i_clk) begin : check_words
        t_perm_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: data %h last %b user %b",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tdata[3:0] !== want.value) begin
                    $error("element_value: expected %0d, got %0d", want.value, m_axis_tdata[3:0]);
                    errors++;
                end
                if (m_axis_tdata[6:4] !== want.pos) begin
                    $error("position: expected %0d, got %0d", want.pos, m_axis_tdata[6:4]);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser !== want.exhausted) begin
                    $error("exhausted: expected %0d, got %0d", want.exhausted, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // stops a hung run: no word moved on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_count();
        test_single_element();
        test_full_walk();
        test_wide_count();
        test_random_runs();
        drain_results();
        repeat (60) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d expected words never arrived", expected_words.size());
            errors++;
        end
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
